>>> hw/rtl/lfmc_pkg.sv
// Shared types, codes and constants for the line-follow motion controller.
// Used by line_follow_motion_controller_core; depends on nothing.
package lfmc_pkg;

   typedef logic signed [7:0]  duty_type;
   typedef logic signed [1:0]  err_type;
   typedef logic signed [5:0]  esum_type;
   typedef logic signed [15:0] wide_type;
   typedef logic signed [23:0] acc_type;

   localparam int DutyLimit = 100;
   localparam int SumLimit  = 20;
   localparam int CmdTurn   = 10;
   localparam int RoundHalf = 128;

   // drive commands
   localparam logic [2:0] CMD_STOP  = 3'd0;
   localparam logic [2:0] CMD_FWD   = 3'd1;
   localparam logic [2:0] CMD_BACK  = 3'd2;
   localparam logic [2:0] CMD_LEFT  = 3'd3;
   localparam logic [2:0] CMD_RIGHT = 3'd4;

   // steering styles
   localparam logic [1:0] STYLE_DIFF = 2'd0;
   localparam logic [1:0] STYLE_PID  = 2'd1;
   localparam logic [1:0] STYLE_NONE = 2'd2;

   // configuration register indexes
   localparam logic [2:0] CSR_BASE_DUTY  = 3'd0;
   localparam logic [2:0] CSR_GAIN_P     = 3'd1;
   localparam logic [2:0] CSR_GAIN_I     = 3'd2;
   localparam logic [2:0] CSR_GAIN_D     = 3'd3;
   localparam logic [2:0] CSR_STEER      = 3'd4;
   localparam logic [2:0] CSR_TURN_FRONT = 3'd5;
   localparam logic [2:0] CSR_TURN_REAR  = 3'd6;
   localparam logic [2:0] CSR_LINE_LEVEL = 3'd7;

   // clamp a wide duty to the wheel range
   function automatic duty_type sat_duty(input wide_type v);
      duty_type r;
      if (v > wide_type'(DutyLimit)) begin
         r = duty_type'(DutyLimit);
      end else if (v < -wide_type'(DutyLimit)) begin
         r = -duty_type'(DutyLimit);
      end else begin
         r = v[7:0];
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/line_follow_motion_controller_core.sv
// Top level of the line-follow motion controller: input register, control/PID
// update and result register. Depends on lfmc_pkg.
//
// One result per item: rsp_valid rises once the item has passed the input register into the
// result register, and one item is accepted every cycle while the result side keeps taking
// results. The rate is set by the state update (PID integral, error memory, wheel duties),
// which is combinational between the input register and the result register; the result
// register holds the wheel duties themselves.
// Configuration writes are taken in any cycle and should be made while idle.
module line_follow_motion_controller_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_mode,
   input  logic                req_sense_left,
   input  logic                req_sense_mid,
   input  logic                req_sense_right,
   input  logic [2:0]          req_drive_cmd,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [7:0]   rsp_duty_left_front,
   output logic signed [7:0]   rsp_duty_left_rear,
   output logic signed [7:0]   rsp_duty_right_front,
   output logic signed [7:0]   rsp_duty_right_rear,
   output logic                rsp_following_line,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [2:0]          csr_index,
   input  logic [15:0]         csr_data
);

   // configuration
   logic [6:0]  base_duty_ff;
   logic [15:0] gain_p_ff, gain_i_ff, gain_d_ff;
   logic [1:0]  steer_style_ff;
   logic [6:0]  turn_front_ff, turn_rear_ff;
   logic        line_level_ff;

   // input register
   logic        s1_valid_ff;
   logic        s1_mode_ff, s1_left_ff, s1_mid_ff, s1_right_ff;
   logic [2:0]  s1_cmd_ff;

   // controller state
   logic                  line_mode_ff, line_mode_in;
   logic [2:0]            last_cmd_ff, last_cmd_in;
   lfmc_pkg::err_type     track_err_ff, track_err_in;
   lfmc_pkg::err_type     prior_err_ff, prior_err_in;
   lfmc_pkg::esum_type    err_sum_ff, err_sum_in;
   lfmc_pkg::duty_type    duty_lf_ff, duty_lr_ff, duty_rf_ff, duty_rr_ff;
   lfmc_pkg::duty_type    duty_lf_in, duty_lr_in, duty_rf_in, duty_rr_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic s1_adv, s1_fire, req_fire;

   assign s1_adv    = !rsp_valid_ff || rsp_ready;
   assign s1_fire   = s1_valid_ff && s1_adv;
   assign req_ready = !s1_valid_ff || s1_adv;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_duty_ff   <= 7'd50;
         gain_p_ff      <= 16'd10240;
         gain_i_ff      <= 16'd64;
         gain_d_ff      <= 16'd77;
         steer_style_ff <= lfmc_pkg::STYLE_DIFF;
         turn_front_ff  <= 7'd10;
         turn_rear_ff   <= 7'd10;
         line_level_ff  <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index)
            lfmc_pkg::CSR_BASE_DUTY:  base_duty_ff   <= csr_data[6:0];
            lfmc_pkg::CSR_GAIN_P:     gain_p_ff      <= csr_data;
            lfmc_pkg::CSR_GAIN_I:     gain_i_ff      <= csr_data;
            lfmc_pkg::CSR_GAIN_D:     gain_d_ff      <= csr_data;
            lfmc_pkg::CSR_STEER:      steer_style_ff <= csr_data[1:0];
            lfmc_pkg::CSR_TURN_FRONT: turn_front_ff  <= csr_data[6:0];
            lfmc_pkg::CSR_TURN_REAR:  turn_rear_ff   <= csr_data[6:0];
            lfmc_pkg::CSR_LINE_LEVEL: line_level_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_mode_ff  <= req_mode;
         s1_left_ff  <= req_sense_left;
         s1_mid_ff   <= req_sense_mid;
         s1_right_ff <= req_sense_right;
         s1_cmd_ff   <= req_drive_cmd;
      end
   end

   // ---------------------------------------------------------------- update
   logic                 on_l, on_m, on_r;
   lfmc_pkg::wide_type   base_w, front_w, rear_w, turn_w;
   lfmc_pkg::err_type    pid_err;
   logic signed [6:0]    esum_raw;
   lfmc_pkg::esum_type   pid_sum;
   logic signed [2:0]    delta;
   lfmc_pkg::acc_type    p_term, i_term, d_term, acc, acc_adj;
   logic signed [22:0]   i_prod;
   lfmc_pkg::wide_type   drive, plus_w, minus_w;

   assign on_l    = (s1_left_ff == line_level_ff);
   assign on_m    = (s1_mid_ff == line_level_ff);
   assign on_r    = (s1_right_ff == line_level_ff);
   assign base_w  = lfmc_pkg::wide_type'({9'd0, base_duty_ff});
   assign front_w = lfmc_pkg::wide_type'({9'd0, turn_front_ff});
   assign rear_w  = lfmc_pkg::wide_type'({9'd0, turn_rear_ff});
   assign turn_w  = lfmc_pkg::wide_type'(lfmc_pkg::CmdTurn);

   // PID path: left wins over right, right over middle; none keeps the error
   always_comb begin
      if (on_l) begin
         pid_err = 2'sb11;
      end else if (on_r) begin
         pid_err = 2'sb01;
      end else if (on_m) begin
         pid_err = 2'sb00;
      end else begin
         pid_err = track_err_ff;
      end
      esum_raw = 7'(err_sum_ff) + 7'(pid_err);
      if (esum_raw > 7'(lfmc_pkg::SumLimit)) begin
         pid_sum = 6'(lfmc_pkg::SumLimit);
      end else if (esum_raw < -7'(lfmc_pkg::SumLimit)) begin
         pid_sum = -6'(lfmc_pkg::SumLimit);
      end else begin
         pid_sum = esum_raw[5:0];
      end
      delta = 3'(pid_err) - 3'(prior_err_ff);
      case (pid_err)
         2'sb01:  p_term = lfmc_pkg::acc_type'({8'd0, gain_p_ff});
         2'sb11:  p_term = -lfmc_pkg::acc_type'({8'd0, gain_p_ff});
         default: p_term = '0;
      endcase
      i_prod = $signed({1'b0, gain_i_ff}) * pid_sum;
      i_term = 24'(i_prod);
      // delta is in -2..2: shift and negate
      case (delta)
         3'sb001: d_term = lfmc_pkg::acc_type'({8'd0, gain_d_ff});
         3'sb010: d_term = lfmc_pkg::acc_type'({7'd0, gain_d_ff, 1'b0});
         3'sb111: d_term = -lfmc_pkg::acc_type'({8'd0, gain_d_ff});
         3'sb110: d_term = -lfmc_pkg::acc_type'({7'd0, gain_d_ff, 1'b0});
         default: d_term = '0;
      endcase
      acc = p_term + i_term + d_term + lfmc_pkg::acc_type'(lfmc_pkg::RoundHalf);
      // round toward zero on the divide by 256
      acc_adj = acc[23] ? acc + 24'sd255 : acc;
      drive   = acc_adj[23:8];
      plus_w  = base_w + drive;
      minus_w = base_w - drive;
   end

   always_comb begin
      line_mode_in = line_mode_ff;
      last_cmd_in  = last_cmd_ff;
      track_err_in = track_err_ff;
      prior_err_in = prior_err_ff;
      err_sum_in   = err_sum_ff;
      duty_lf_in   = duty_lf_ff;
      duty_lr_in   = duty_lr_ff;
      duty_rf_in   = duty_rf_ff;
      duty_rr_in   = duty_rr_ff;
      if (s1_mode_ff) begin
         track_err_in = '0;
         prior_err_in = '0;
         err_sum_in   = '0;
         duty_lf_in   = '0;
         duty_lr_in   = '0;
         duty_rf_in   = '0;
         duty_rr_in   = '0;
         line_mode_in = !line_mode_ff;
      end else if (line_mode_ff) begin
         if (on_l && on_m && on_r) begin
            duty_lf_in = '0;
            duty_lr_in = '0;
            duty_rf_in = '0;
            duty_rr_in = '0;
         end else if (steer_style_ff == lfmc_pkg::STYLE_DIFF) begin
            if (on_l) begin
               duty_lf_in = lfmc_pkg::sat_duty(front_w);
               duty_lr_in = lfmc_pkg::sat_duty(rear_w);
               duty_rf_in = lfmc_pkg::sat_duty(base_w);
               duty_rr_in = lfmc_pkg::sat_duty(base_w);
            end else if (on_r) begin
               duty_lf_in = lfmc_pkg::sat_duty(base_w);
               duty_lr_in = lfmc_pkg::sat_duty(base_w);
               duty_rf_in = lfmc_pkg::sat_duty(front_w);
               duty_rr_in = lfmc_pkg::sat_duty(rear_w);
            end else if (on_m) begin
               duty_lf_in = lfmc_pkg::sat_duty(base_w);
               duty_lr_in = lfmc_pkg::sat_duty(base_w);
               duty_rf_in = lfmc_pkg::sat_duty(base_w);
               duty_rr_in = lfmc_pkg::sat_duty(base_w);
            end
         end else if (steer_style_ff == lfmc_pkg::STYLE_PID) begin
            track_err_in = pid_err;
            prior_err_in = pid_err;
            err_sum_in   = pid_sum;
            duty_lf_in   = lfmc_pkg::sat_duty(plus_w);
            duty_lr_in   = lfmc_pkg::sat_duty(plus_w);
            duty_rf_in   = lfmc_pkg::sat_duty(minus_w);
            duty_rr_in   = lfmc_pkg::sat_duty(minus_w);
         end
      end else if (s1_cmd_ff != last_cmd_ff) begin
         last_cmd_in = s1_cmd_ff;
         case (s1_cmd_ff)
            lfmc_pkg::CMD_STOP: begin
               duty_lf_in = '0;
               duty_lr_in = '0;
               duty_rf_in = '0;
               duty_rr_in = '0;
            end
            lfmc_pkg::CMD_FWD: begin
               duty_lf_in = lfmc_pkg::sat_duty(base_w);
               duty_lr_in = lfmc_pkg::sat_duty(base_w);
               duty_rf_in = lfmc_pkg::sat_duty(base_w);
               duty_rr_in = lfmc_pkg::sat_duty(base_w);
            end
            lfmc_pkg::CMD_BACK: begin
               duty_lf_in = lfmc_pkg::sat_duty(-base_w);
               duty_lr_in = lfmc_pkg::sat_duty(-base_w);
               duty_rf_in = lfmc_pkg::sat_duty(-base_w);
               duty_rr_in = lfmc_pkg::sat_duty(-base_w);
            end
            lfmc_pkg::CMD_LEFT: begin
               duty_lf_in = lfmc_pkg::sat_duty(turn_w);
               duty_lr_in = lfmc_pkg::sat_duty(turn_w);
               duty_rf_in = lfmc_pkg::sat_duty(base_w);
               duty_rr_in = lfmc_pkg::sat_duty(base_w);
            end
            lfmc_pkg::CMD_RIGHT: begin
               duty_lf_in = lfmc_pkg::sat_duty(base_w);
               duty_lr_in = lfmc_pkg::sat_duty(base_w);
               duty_rf_in = lfmc_pkg::sat_duty(turn_w);
               duty_rr_in = lfmc_pkg::sat_duty(turn_w);
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      if (s1_adv) begin
         rsp_valid_in = s1_valid_ff;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // state and result register advance together, so the duties are the result
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         line_mode_ff <= 1'b0;
         last_cmd_ff  <= lfmc_pkg::CMD_STOP;
         track_err_ff <= '0;
         prior_err_ff <= '0;
         err_sum_ff   <= '0;
         duty_lf_ff   <= '0;
         duty_lr_ff   <= '0;
         duty_rf_ff   <= '0;
         duty_rr_ff   <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (s1_fire) begin
            line_mode_ff <= line_mode_in;
            last_cmd_ff  <= last_cmd_in;
            track_err_ff <= track_err_in;
            prior_err_ff <= prior_err_in;
            err_sum_ff   <= err_sum_in;
            duty_lf_ff   <= duty_lf_in;
            duty_lr_ff   <= duty_lr_in;
            duty_rf_ff   <= duty_rf_in;
            duty_rr_ff   <= duty_rr_in;
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_duty_left_front  = duty_lf_ff;
   assign rsp_duty_left_rear   = duty_lr_ff;
   assign rsp_duty_right_front = duty_rf_ff;
   assign rsp_duty_right_rear  = duty_rr_ff;
   assign rsp_following_line   = line_mode_ff;

   // ------------------------------------------------------------ assertions
   a_sum_clamped: assert property (@(posedge clock) disable iff (reset)
      err_sum_ff <= 6'sd20 && err_sum_ff >= -6'sd20)
      else $error("integral outside clamp");

   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (duty_lf_ff <= 8'sd100 && duty_lf_ff >= -8'sd100 &&
                        duty_rf_ff <= 8'sd100 && duty_rf_ff >= -8'sd100))
      else $error("wheel duty outside range");

   a_toggle_clears: assert property (@(posedge clock) disable iff (reset)
      s1_fire && s1_mode_ff |=> err_sum_ff == '0 && prior_err_ff == '0 &&
                               duty_lf_ff == '0 && duty_rr_ff == '0)
      else $error("toggle did not clear controller");

   a_repeat_cmd_holds: assert property (@(posedge clock) disable iff (reset)
      s1_fire && !s1_mode_ff && !line_mode_ff && s1_cmd_ff == last_cmd_ff
      |=> $stable(duty_lf_ff) && $stable(duty_rf_ff) && $stable(duty_rr_ff))
      else $error("repeated command changed duties");

   a_no_lost_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff)
      else $error("result dropped while stalled");

endmodule

>>> dv/tb_line_follow_motion_controller_core.sv
// Testbench for line_follow_motion_controller_core: random and directed ticks against a
// cycle-free predictor of the wheel duties, with valid/ready idling on both sides.
// Depends on lfmc_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_line_follow_motion_controller_core;

   typedef struct packed {
      logic       mode;
      logic       sense_left;
      logic       sense_mid;
      logic       sense_right;
      logic [2:0] drive_cmd;
   } tick_item_type;

   typedef struct packed {
      lfmc_pkg::duty_type left_front;
      lfmc_pkg::duty_type left_rear;
      lfmc_pkg::duty_type right_front;
      lfmc_pkg::duty_type right_rear;
      logic               following_line;
   } wheel_result_type;

   typedef struct packed {
      logic [6:0]  base_duty;
      logic [15:0] gain_p;
      logic [15:0] gain_i;
      logic [15:0] gain_d;
      logic [1:0]  steer_style;
      logic [6:0]  turn_front;
      logic [6:0]  turn_rear;
      logic        line_level;
   } steer_settings_type;

   localparam int LongHold = 60;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_mode = 1'b0;
   logic              req_sense_left = 1'b0;
   logic              req_sense_mid = 1'b0;
   logic              req_sense_right = 1'b0;
   logic [2:0]        req_drive_cmd = lfmc_pkg::CMD_STOP;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic signed [7:0] rsp_duty_left_front;
   logic signed [7:0] rsp_duty_left_rear;
   logic signed [7:0] rsp_duty_right_front;
   logic signed [7:0] rsp_duty_right_rear;
   logic              rsp_following_line;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [2:0]        csr_index = lfmc_pkg::CSR_BASE_DUTY;
   logic [15:0]       csr_data = '0;

   line_follow_motion_controller_core u_dut (.*);

   always #5 clock = ~clock;

   tick_item_type    pending_ticks[$];
   wheel_result_type expected_wheels[$];
   tick_item_type    next_tick;
   logic             req_fire_q = 1'b0;
   int               send_idle_pct = 0;
   int               recv_idle_pct = 0;
   int               hold_req_count = 0;
   int               hold_served = 0;
   int               hold_left = 0;
   int               fail_count = 0;

   // predictor copy of configuration and state
   logic [6:0]          base_duty_m;
   logic [15:0]         gain_p_m, gain_i_m, gain_d_m;
   logic [1:0]          style_m;
   logic [6:0]          turn_front_m, turn_rear_m;
   logic                level_m;
   logic                line_mode_m;
   logic [2:0]          last_cmd_m;
   lfmc_pkg::err_type   err_now, err_prev;
   lfmc_pkg::esum_type  err_sum;
   lfmc_pkg::duty_type  wheel_m[4];

   function automatic lfmc_pkg::duty_type clamp_duty(input int v);
      if (v > lfmc_pkg::DutyLimit) return lfmc_pkg::duty_type'(lfmc_pkg::DutyLimit);
      if (v < -lfmc_pkg::DutyLimit) return lfmc_pkg::duty_type'(-lfmc_pkg::DutyLimit);
      return lfmc_pkg::duty_type'(v);
   endfunction

   function automatic void set_wheels(input int lf, input int lr, input int rf, input int rr);
      wheel_m[0] = clamp_duty(lf);
      wheel_m[1] = clamp_duty(lr);
      wheel_m[2] = clamp_duty(rf);
      wheel_m[3] = clamp_duty(rr);
   endfunction

   function automatic void clear_predictor();
      base_duty_m  = 7'd50;
      gain_p_m     = 16'd10240;
      gain_i_m     = 16'd64;
      gain_d_m     = 16'd77;
      style_m      = lfmc_pkg::STYLE_DIFF;
      turn_front_m = 7'd10;
      turn_rear_m  = 7'd10;
      level_m      = 1'b1;
      line_mode_m  = 1'b0;
      last_cmd_m   = lfmc_pkg::CMD_STOP;
      err_now      = '0;
      err_prev     = '0;
      err_sum      = '0;
      set_wheels(0, 0, 0, 0);
   endfunction

   function automatic void steer_pid();
      int b, total, drive, acc;
      b = int'(base_duty_m);
      acc = int'(err_sum) + int'(err_now);
      if (acc > lfmc_pkg::SumLimit) acc = lfmc_pkg::SumLimit;
      if (acc < -lfmc_pkg::SumLimit) acc = -lfmc_pkg::SumLimit;
      err_sum = lfmc_pkg::esum_type'(acc);
      total = int'(gain_p_m) * int'(err_now) + int'(gain_i_m) * int'(err_sum)
            + int'(gain_d_m) * (int'(err_now) - int'(err_prev)) + lfmc_pkg::RoundHalf;
      drive = total / 256;   // signed int division truncates toward zero
      err_prev = err_now;
      set_wheels(b + drive, b + drive, b - drive, b - drive);
   endfunction

   function automatic wheel_result_type advance_wheels(input tick_item_type t);
      wheel_result_type r;
      logic l, m, rt;
      int b;
      b  = int'(base_duty_m);
      l  = (t.sense_left == level_m);
      m  = (t.sense_mid == level_m);
      rt = (t.sense_right == level_m);
      if (t.mode) begin
         err_now = '0;
         err_prev = '0;
         err_sum = '0;
         set_wheels(0, 0, 0, 0);
         line_mode_m = ~line_mode_m;
      end else if (line_mode_m) begin
         if (l && m && rt) begin
            set_wheels(0, 0, 0, 0);
         end else if (style_m == lfmc_pkg::STYLE_DIFF) begin
            if (l) set_wheels(int'(turn_front_m), int'(turn_rear_m), b, b);
            else if (rt) set_wheels(b, b, int'(turn_front_m), int'(turn_rear_m));
            else if (m) set_wheels(b, b, b, b);
         end else if (style_m == lfmc_pkg::STYLE_PID) begin
            // no sensor on the line: keep the previous error
            if (l) err_now = -2'sd1;
            else if (rt) err_now = 2'sd1;
            else if (m) err_now = 2'sd0;
            steer_pid();
         end
      end else if (t.drive_cmd != last_cmd_m) begin
         last_cmd_m = t.drive_cmd;
         case (t.drive_cmd)
            lfmc_pkg::CMD_STOP:  set_wheels(0, 0, 0, 0);
            lfmc_pkg::CMD_FWD:   set_wheels(b, b, b, b);
            lfmc_pkg::CMD_BACK:  set_wheels(-b, -b, -b, -b);
            lfmc_pkg::CMD_LEFT:  set_wheels(lfmc_pkg::CmdTurn, lfmc_pkg::CmdTurn, b, b);
            lfmc_pkg::CMD_RIGHT: set_wheels(b, b, lfmc_pkg::CmdTurn, lfmc_pkg::CmdTurn);
            default: ;
         endcase
      end
      r.left_front     = wheel_m[0];
      r.left_rear      = wheel_m[1];
      r.right_front    = wheel_m[2];
      r.right_rear     = wheel_m[3];
      r.following_line = line_mode_m;
      return r;
   endfunction

   // sender: hold the item until taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire_q) begin
         if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_tick = pending_ticks.pop_front();
            req_valid       <= 1'b1;
            req_mode        <= next_tick.mode;
            req_sense_left  <= next_tick.sense_left;
            req_sense_mid   <= next_tick.sense_mid;
            req_sense_right <= next_tick.sense_right;
            req_drive_cmd   <= next_tick.drive_cmd;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_served != hold_req_count) begin
         hold_served <= hold_req_count;
         hold_left   <= LongHold;
         rsp_ready   <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // monitor: mirror config writes, predict on accept, check results
   always @(posedge clock) begin
      tick_item_type    seen;
      wheel_result_type got, want;
      if (reset) begin
         req_fire_q <= 1'b0;
         clear_predictor();
      end else begin
         req_fire_q <= req_valid && req_ready;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               lfmc_pkg::CSR_BASE_DUTY:  base_duty_m  = csr_data[6:0];
               lfmc_pkg::CSR_GAIN_P:     gain_p_m     = csr_data;
               lfmc_pkg::CSR_GAIN_I:     gain_i_m     = csr_data;
               lfmc_pkg::CSR_GAIN_D:     gain_d_m     = csr_data;
               lfmc_pkg::CSR_STEER:      style_m      = csr_data[1:0];
               lfmc_pkg::CSR_TURN_FRONT: turn_front_m = csr_data[6:0];
               lfmc_pkg::CSR_TURN_REAR:  turn_rear_m  = csr_data[6:0];
               lfmc_pkg::CSR_LINE_LEVEL: level_m      = csr_data[0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            got.left_front     = rsp_duty_left_front;
            got.left_rear      = rsp_duty_left_rear;
            got.right_front    = rsp_duty_right_front;
            got.right_rear     = rsp_duty_right_rear;
            got.following_line = rsp_following_line;
            if (expected_wheels.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected result lf=%0d lr=%0d rf=%0d rr=%0d line=%0b",
                           $realtime, got.left_front, got.left_rear, got.right_front,
                           got.right_rear, got.following_line);
            end else begin
               want = expected_wheels.pop_front();
               if (got.left_front !== want.left_front || got.left_rear !== want.left_rear ||
                   got.right_front !== want.right_front ||
                   got.right_rear !== want.right_rear ||
                   got.following_line !== want.following_line) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"%0t: mismatch expected lf=%0d lr=%0d rf=%0d rr=%0d line=%0b",
                               " got lf=%0d lr=%0d rf=%0d rr=%0d line=%0b"},
                              $realtime, want.left_front, want.left_rear, want.right_front,
                              want.right_rear, want.following_line, got.left_front,
                              got.left_rear, got.right_front, got.right_rear,
                              got.following_line);
               end
            end
         end
         if (req_valid && req_ready) begin
            seen.mode        = req_mode;
            seen.sense_left  = req_sense_left;
            seen.sense_mid   = req_sense_mid;
            seen.sense_right = req_sense_right;
            seen.drive_cmd   = req_drive_cmd;
            expected_wheels.push_back(advance_wheels(seen));
         end
      end
   end

   task automatic csr_write(input logic [2:0] idx, input logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   task automatic apply_settings(input steer_settings_type s);
      csr_write(lfmc_pkg::CSR_BASE_DUTY, 16'(s.base_duty));
      csr_write(lfmc_pkg::CSR_GAIN_P, s.gain_p);
      csr_write(lfmc_pkg::CSR_GAIN_I, s.gain_i);
      csr_write(lfmc_pkg::CSR_GAIN_D, s.gain_d);
      csr_write(lfmc_pkg::CSR_STEER, 16'(s.steer_style));
      csr_write(lfmc_pkg::CSR_TURN_FRONT, 16'(s.turn_front));
      csr_write(lfmc_pkg::CSR_TURN_REAR, 16'(s.turn_rear));
      csr_write(lfmc_pkg::CSR_LINE_LEVEL, 16'(s.line_level));
   endtask

   function automatic steer_settings_type settings_for(input int p);
      steer_settings_type s;
      case (p)
         0: s = '{7'd50, 16'd10240, 16'd64, 16'd77, lfmc_pkg::STYLE_DIFF, 7'd10, 7'd10, 1'b1};
         1: s = '{7'd50, 16'd10240, 16'd64, 16'd77, lfmc_pkg::STYLE_PID, 7'd10, 7'd10, 1'b1};
         2: s = '{7'd0, 16'd0, 16'd0, 16'd0, lfmc_pkg::STYLE_PID, 7'd0, 7'd0, 1'b0};
         3: s = '{7'd127, 16'hFFFF, 16'hFFFF, 16'hFFFF, lfmc_pkg::STYLE_PID, 7'd127, 7'd127,
                  1'b1};
         4: s = '{7'd100, 16'd256, 16'd512, 16'd128, lfmc_pkg::STYLE_PID, 7'd100, 7'd100,
                  1'b0};
         5: s = '{7'd127, 16'd0, 16'd0, 16'd0, lfmc_pkg::STYLE_DIFF, 7'd127, 7'd127, 1'b0};
         6: s = '{7'd30, 16'd1000, 16'd300, 16'd2000, lfmc_pkg::STYLE_NONE, 7'd20, 7'd5, 1'b1};
         // style code outside the defined set acts as no steering
         7: s = '{7'd60, 16'd5000, 16'd100, 16'd800, 2'd3, 7'd40, 7'd0, 1'b0};
         8: s = '{7'd1, 16'hFFFF, 16'd0, 16'hFFFF, lfmc_pkg::STYLE_PID, 7'd1, 7'd1, 1'b1};
         9: s = '{7'd80, 16'd300, 16'd2000, 16'd50, lfmc_pkg::STYLE_PID, 7'd50, 7'd50, 1'b0};
         default: begin
            s.base_duty   = 7'($urandom_range(127));
            s.gain_p      = 16'($urandom_range(16'hFFFF));
            s.gain_i      = 16'($urandom_range(16'hFFFF));
            s.gain_d      = 16'($urandom_range(16'hFFFF));
            s.steer_style = 2'($urandom_range(3));
            s.turn_front  = 7'($urandom_range(127));
            s.turn_rear   = 7'($urandom_range(127));
            s.line_level  = 1'($urandom_range(1));
         end
      endcase
      return s;
   endfunction

   function automatic void queue_tick(input logic mode, input logic [2:0] sensors,
                                      input logic [2:0] cmd);
      pending_ticks.push_back('{mode, sensors[2], sensors[1], sensors[0], cmd});
   endfunction

   // sensor patterns are held for runs so the integral can reach its clamp
   function automatic void queue_random_ticks(input int count);
      int n, run_left;
      logic [2:0] pattern, sensors, cmd;
      run_left = 0;
      pattern = '0;
      for (n = 0; n < count; n++) begin
         if (run_left == 0) begin
            pattern  = 3'($urandom_range(7));
            run_left = $urandom_range(1, 30);
         end
         run_left--;
         sensors = ($urandom_range(99) < 10) ? 3'($urandom_range(7)) : pattern;
         cmd = ($urandom_range(99) < 85) ? 3'($urandom_range(4)) : 3'($urandom_range(5, 7));
         queue_tick($urandom_range(99) < 3, sensors, cmd);
      end
   endfunction

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_ticks.size() != 0 || req_valid || expected_wheels.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      int p, s;
      send_idle_pct = 9;
      recv_idle_pct = 85;
      repeat (12) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // command mode: repeats, every command, unknown codes
      queue_tick(1'b0, 3'b000, lfmc_pkg::CMD_STOP);
      queue_tick(1'b0, 3'b111, lfmc_pkg::CMD_FWD);
      queue_tick(1'b0, 3'b000, lfmc_pkg::CMD_FWD);
      queue_tick(1'b0, 3'b000, lfmc_pkg::CMD_BACK);
      queue_tick(1'b0, 3'b000, lfmc_pkg::CMD_LEFT);
      queue_tick(1'b0, 3'b000, lfmc_pkg::CMD_RIGHT);
      queue_tick(1'b0, 3'b000, 3'd5);
      queue_tick(1'b0, 3'b000, 3'd7);
      queue_tick(1'b0, 3'b000, lfmc_pkg::CMD_FWD);
      // line mode, differential: every sensor pattern, then back without reapply
      queue_tick(1'b1, 3'b000, lfmc_pkg::CMD_FWD);
      for (s = 0; s < 8; s++) queue_tick(1'b0, 3'(s), lfmc_pkg::CMD_STOP);
      queue_tick(1'b1, 3'b000, lfmc_pkg::CMD_STOP);
      queue_tick(1'b0, 3'b000, lfmc_pkg::CMD_FWD);
      queue_tick(1'b0, 3'b000, 3'd6);
      wait_idle();

      // PID steering: repeated error, lost line, all black
      apply_settings(settings_for(1));
      queue_tick(1'b1, 3'b000, lfmc_pkg::CMD_STOP);
      queue_tick(1'b0, 3'b100, lfmc_pkg::CMD_STOP);
      queue_tick(1'b0, 3'b100, lfmc_pkg::CMD_STOP);
      queue_tick(1'b0, 3'b000, lfmc_pkg::CMD_STOP);
      queue_tick(1'b0, 3'b001, lfmc_pkg::CMD_STOP);
      queue_tick(1'b0, 3'b010, lfmc_pkg::CMD_STOP);
      queue_tick(1'b0, 3'b111, lfmc_pkg::CMD_STOP);
      queue_tick(1'b1, 3'b000, lfmc_pkg::CMD_STOP);
      wait_idle();

      for (p = 0; p < 12; p++) begin
         if (p == 4) begin
            send_idle_pct = 85;
            recv_idle_pct = 9;
         end else if (p == 8) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         apply_settings(settings_for(p));
         if (p == 8) hold_req_count++;
         queue_random_ticks(100);
         wait_idle();
      end

      repeat (10) @(posedge clock);
      if (fail_count == 0 && expected_wheels.size() == 0) begin
         $display("[line_follow_motion_controller_core] OK");
      end else begin
         $display("[line_follow_motion_controller_core] ERROR");
      end
      $finish;
   end

   initial begin
      #3ms;
      $display("[line_follow_motion_controller_core] ERROR");
      $finish;
   end

endmodule
